[hdl/isort_pkg.sv]
// ----------------------------------------------------------------------------
// Insertion sorter package
// Shared types and default constants for the insertion sorter.
// ----------------------------------------------------------------------------
package isort_pkg;

    // Default number of keys the sorted store holds.
    localparam int DEFAULT_CAPACITY = 16;

    // Width of one key.
    localparam int KEY_W = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;     // place the incoming key into the store
        logic shift_out;  // drop the head entry and move the rest down
    } isort_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_limit;   // one free place left: the next key fills the store
        logic one_left;   // exactly one key remains to be sent
    } isort_status_t;

endpackage

[hdl/isort_datapath.sv]
// ----------------------------------------------------------------------------
// Insertion sorter datapath
// A row of compare-and-shift cells that holds the sorted keys and the count.
// ----------------------------------------------------------------------------
module isort_datapath #(
    parameter int CAPACITY = isort_pkg::DEFAULT_CAPACITY
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  isort_pkg::isort_cmd_t         cmd,
    output isort_pkg::isort_status_t      status,
    input  logic signed [isort_pkg::KEY_W-1:0] key_value,
    output logic signed [isort_pkg::KEY_W-1:0] head_value
);
    import isort_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [KEY_W-1:0] store_reg  [CAPACITY];
    logic signed [KEY_W-1:0] store_next [CAPACITY];
    logic [CAPACITY-1:0]     gt;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;

    // Each occupied cell compares its entry against the incoming key.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            gt[i] = (CW'(i) < count_reg) && (store_reg[i] > key_value);
        end
    end

    // Cell update: insert moves larger entries up one place, shift-out moves
    // every entry down toward the head.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            store_next[i] = store_reg[i];
            if (cmd.insert) begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                    store_next[i] = store_reg[(i > 0) ? i - 1 : 0];
                end else if (gt[i] || CW'(i) == count_reg) begin
                    store_next[i] = key_value;
                end
            end else if (cmd.shift_out) begin
                if (i < CAPACITY - 1) begin
                    store_next[i] = store_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            store_reg[i] <= store_next[i];
        end
    end

    // Number of keys held.
    always_comb begin
        count_next = count_reg;
        if (cmd.insert) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.shift_out) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign status.at_limit = (count_reg == CW'(CAPACITY - 1));
    assign status.one_left = (count_reg == CW'(1));
    assign head_value      = store_reg[0];

    // Sending never happens from an empty store.
    a_shift_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_out |-> count_reg != '0)
        else $error("shift-out on an empty store");

    // Loading never goes past capacity.
    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> count_reg < CW'(CAPACITY))
        else $error("insert into a full store");

    // Each insert adds exactly one key.
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |=> count_reg == $past(count_reg) + CW'(1))
        else $error("count did not advance on insert");

endmodule

[hdl/isort_ctrl.sv]
// ----------------------------------------------------------------------------
// Insertion sorter controller
// Alternates between loading keys and sending the sorted run.
// ----------------------------------------------------------------------------
module isort_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_is_final,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_run_end,
    output isort_pkg::isort_cmd_t    cmd,
    input  isort_pkg::isort_status_t status
);
    import isort_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_SEND = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Handshakes and datapath commands follow the state.
    always_comb begin
        s_ready       = (state_reg == ST_LOAD);
        m_valid       = (state_reg == ST_SEND);
        m_run_end     = status.one_left;
        cmd.insert    = s_ready && s_valid;
        cmd.shift_out = m_valid && m_ready;
    end

    // A final mark or a filling key ends loading; the last transaction
    // of the run ends sending.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (cmd.insert && (s_is_final || status.at_limit)) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (cmd.shift_out && status.one_left) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Exactly one state bit is set at all times.
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register lost its one-hot code");

    // A final key always starts sending in the next cycle.
    a_final_send: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.insert && s_is_final) |=> state_reg == ST_SEND)
        else $error("final key did not start sending");

    // Loading and sending never overlap.
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.insert && cmd.shift_out))
        else $error("insert and shift-out in the same cycle");

endmodule

[hdl/insertion_sorter.sv]
// ----------------------------------------------------------------------------
// Insertion sorter
// The smallest key is offered in the cycle after the last key is taken.
// A run of N keys is loaded one key per cycle through the compare-and-shift
// cells while loading, then sent one key per transaction.
// Input is not taken while a run is being sent.
// Reset (aresetn, synchronous, active low) empties the store and starts loading.
// ----------------------------------------------------------------------------
module insertion_sorter #(
    parameter int CAPACITY = isort_pkg::DEFAULT_CAPACITY
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [isort_pkg::KEY_W-1:0] s_key_value,
    input  logic                               s_is_final,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [isort_pkg::KEY_W-1:0] m_sorted_value,
    output logic                               m_run_end
);
    import isort_pkg::*;

    isort_cmd_t    cmd;
    isort_status_t status;

    // Sequencing of load and send phases.
    isort_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_is_final (s_is_final),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_run_end  (m_run_end),
        .cmd        (cmd),
        .status     (status)
    );

    // Sorted key store.
    isort_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .key_value  (s_key_value),
        .head_value (m_sorted_value)
    );

endmodule
